### rtl/core/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the peer slot table.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int DEF_CAPACITY = 32;

    localparam int ID_W   = 16;
    localparam int ADDR_W = 64;
    localparam int SOCK_W = 17;
    localparam int ACT_W  = 3;
    localparam int SLOT_W = 5;
    localparam int OCC_W  = 6;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 176;

    localparam logic [ACT_W-1:0] ACT_ADD       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_COPY      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FIND_ID   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FIND_SOCK = 3'd4;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_FREE = 2'd1;
    localparam logic [1:0] MODE_ID   = 2'd2;
    localparam logic [1:0] MODE_SOCK = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [SOCK_W-1:0] sock;
    } entry_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   id;
        logic [SOCK_W-1:0] sock;
    } match_key_t;

endpackage

### rtl/core/peer_slot_table_top.sv
// ----------------------------------------------------------------------------
// peer_slot_table_top
// Fixed-capacity peer table with id allocation, scanned one slot per cycle.
// ----------------------------------------------------------------------------
// channel  | signals                                    | content
// s_*      | s_tvalid s_tready s_tdata s_tuser          | action request
// m_*      | m_tvalid m_tready m_tdata m_tuser          | action result
//
// A request is scanned one slot per cycle: the table RAM is read through the
// single compare unit until the first match or the last slot.
// After reset a clearing pass writes every slot with s_tready low. The result
// register holds while m_tvalid is high and m_tready is low; a finished scan
// waits for it, and s_tready stays low until the result is loaded.
// ----------------------------------------------------------------------------
module peer_slot_table_top #(
    parameter int CAPACITY = pst_pkg::DEF_CAPACITY
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_id[15:0], addr_high[79:16], addr_low[143:80], socket_num[160:144]
    input  logic [pst_pkg::IN_DATA_W-1:0]  s_tdata,
    // action[2:0]
    input  logic [pst_pkg::ACT_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot[4:0], out_id[20:5], out_addr_high[84:21], out_addr_low[148:85],
    // out_socket[165:149], occupied[171:166]
    output logic [pst_pkg::OUT_DATA_W-1:0] m_tdata,
    // hit[0]
    output logic                           m_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = $bits(pst_pkg::entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam int PAD_W = pst_pkg::OUT_DATA_W - pst_pkg::SLOT_W - pst_pkg::ID_W
                           - 2 * pst_pkg::ADDR_W - pst_pkg::SOCK_W - pst_pkg::OCC_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [pst_pkg::ID_W-1:0]      next_id_reg, next_id_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    logic [pst_pkg::ACT_W-1:0]     act_reg, act_next;
    pst_pkg::entry_t               item_reg, item_next;
    pst_pkg::match_key_t           key_reg, key_next;
    logic                          res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]              res_idx_reg, res_idx_next;
    pst_pkg::entry_t               res_reg, res_next;
    logic [pst_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    logic                          wr_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [ENT_W-1:0]              wr_data;
    logic [ENT_W-1:0]              rd_data;
    pst_pkg::entry_t               rd_entry;
    pst_pkg::entry_t               ins_entry;
    logic                          match;
    logic                          s_fire;
    logic                          is_insert;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign rd_entry = pst_pkg::entry_t'(rd_data);
    assign rd_addr  = (state_reg == ST_SCAN) ? idx_reg + IDX_W'(1) : '0;
    assign is_insert = (act_reg == pst_pkg::ACT_ADD) || (act_reg == pst_pkg::ACT_COPY);

    always_comb
    begin
        ins_entry       = item_reg;
        ins_entry.valid = 1'b1;
        if (act_reg == pst_pkg::ACT_ADD)
        begin
            ins_entry.id = next_id_reg;
        end
    end

    pst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pst_match u_match (
        .entry (rd_entry),
        .key   (key_reg),
        .match (match)
    );

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        m_tvalid_next = m_tvalid_reg;
        act_next      = act_reg;
        item_next     = item_reg;
        key_next      = key_reg;
        res_hit_next  = res_hit_reg;
        res_idx_next  = res_idx_reg;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr_en         = 1'b0;
        wr_data       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    act_next           = s_tuser;
                    item_next.valid    = 1'b1;
                    item_next.id       = s_tdata[15:0];
                    item_next.addr_high = s_tdata[79:16];
                    item_next.addr_low = s_tdata[143:80];
                    item_next.sock     = s_tdata[160:144];
                    key_next.id        = s_tdata[15:0];
                    key_next.sock      = s_tdata[160:144];
                    case (s_tuser)
                        pst_pkg::ACT_ADD:       key_next.mode = pst_pkg::MODE_FREE;
                        pst_pkg::ACT_COPY:      key_next.mode = pst_pkg::MODE_FREE;
                        pst_pkg::ACT_DELETE:    key_next.mode = pst_pkg::MODE_ID;
                        pst_pkg::ACT_FIND_ID:
                            key_next.mode = (s_tdata[15:0] != '0) ?
                                            pst_pkg::MODE_ID : pst_pkg::MODE_NONE;
                        pst_pkg::ACT_FIND_SOCK:
                            key_next.mode = s_tdata[160] ?
                                            pst_pkg::MODE_NONE : pst_pkg::MODE_SOCK;
                        default:                key_next.mode = pst_pkg::MODE_NONE;
                    endcase
                    res_hit_next = 1'b0;
                    res_idx_next = '0;
                    res_next     = '0;
                    idx_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    res_hit_next = 1'b1;
                    res_idx_next = idx_reg;
                    state_next   = ST_DONE;
                    if (is_insert)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = ins_entry;
                        res_next   = ins_entry;
                        count_next = count_reg + CNT_W'(1);
                        if (act_reg == pst_pkg::ACT_ADD)
                        begin
                            next_id_next = (next_id_reg == '1) ?
                                           pst_pkg::ID_W'(1) : next_id_reg + pst_pkg::ID_W'(1);
                        end
                    end
                    else if (act_reg == pst_pkg::ACT_DELETE)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = rd_entry;
                        wr_data[ENT_W-1] = 1'b0;
                        res_next      = rd_entry;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_next = rd_entry;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_hit_reg;
                    m_tdata_next  = {{PAD_W{1'b0}},
                                     pst_pkg::OCC_W'(count_reg),
                                     res_reg.sock,
                                     res_reg.addr_low,
                                     res_reg.addr_high,
                                     res_reg.id,
                                     pst_pkg::SLOT_W'(res_idx_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            count_reg    <= '0;
            next_id_reg  <= pst_pkg::ID_W'(1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        item_reg    <= item_next;
        key_reg     <= key_next;
        res_hit_reg <= res_hit_next;
        res_idx_reg <= res_idx_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("id counter reached zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("ready held during a scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && match && is_insert)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the entry count");
`endif

endmodule

### rtl/core/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/pst_match.sv
// ----------------------------------------------------------------------------
// pst_match
// Shared compare unit: tests one table entry against the search key.
// ----------------------------------------------------------------------------
module pst_match (
    input  pst_pkg::entry_t     entry,
    input  pst_pkg::match_key_t key,
    output logic                match
);

    always_comb
    begin
        case (key.mode)
            pst_pkg::MODE_FREE: match = !entry.valid;
            pst_pkg::MODE_ID:   match = entry.valid && (entry.id == key.id);
            pst_pkg::MODE_SOCK: match = entry.valid && (entry.sock == key.sock);
            default:            match = 1'b0;
        endcase
    end

endmodule

### test/peer_slot_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// peer_slot_table_top_tb
// Self-checking bench for the peer slot table. Requests are planned up front
// against a shadow table, then driven with random source gaps and sink stalls.
// Every accepted request is applied to a second shadow table, and each result
// transfer is compared field by field with the oldest prediction. The run
// covers empty and full tables, duplicate ids and sockets, unused action
// codes, and ends with a calm stretch that drains the table.
// ----------------------------------------------------------------------------
module peer_slot_table_top_tb;
    import pst_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int PLAN        = 0;
    localparam int LIVE        = 1;
    localparam int N_RANDOM    = 1800;
    localparam int SEG_LEN     = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int PAD_W       = IN_DATA_W - ID_W - 2 * ADDR_W - SOCK_W;

    localparam logic [ACT_W-1:0] ACT_RSVD_MIN = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_MAX = 3'd7;

    localparam int O_ID   = SLOT_W;
    localparam int O_AH   = O_ID + ID_W;
    localparam int O_AL   = O_AH + ADDR_W;
    localparam int O_SOCK = O_AL + ADDR_W;
    localparam int O_OCC  = O_SOCK + SOCK_W;

    typedef struct packed {
        logic              calm;
        logic [ACT_W-1:0]  act;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [SOCK_W-1:0] sock;
    } table_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [SOCK_W-1:0] sock;
        logic [OCC_W-1:0]  occ;
    } action_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [ACT_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    entry_t         slots [2][CAP];
    logic [OCC_W-1:0] fill [2];
    logic [ID_W-1:0]  id_ctr [2];

    table_req_t     pending [$];
    action_result_t result_q [$];
    table_req_t     cur_req;
    logic           calm_now = 1'b0;
    int             src_gap;
    int             snk_gap;
    int             err_cnt = 0;
    int             n_checked = 0;
    int             stall_cycles = 0;

    peer_slot_table_top #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic action_result_t apply_action(input int side, input table_req_t r);
        action_result_t o;
        int             hit_slot;
        o = '0;
        hit_slot = -1;
        case (r.act)
            ACT_ADD, ACT_COPY:
            begin
                for (int k = 0; k < CAP; k++)
                    if (hit_slot < 0 && !slots[side][k].valid)
                        hit_slot = k;
                if (hit_slot >= 0)
                begin
                    slots[side][hit_slot].valid     = 1'b1;
                    slots[side][hit_slot].addr_high = r.addr_high;
                    slots[side][hit_slot].addr_low  = r.addr_low;
                    slots[side][hit_slot].sock      = r.sock;
                    if (r.act == ACT_ADD)
                    begin
                        slots[side][hit_slot].id = id_ctr[side];
                        id_ctr[side] = (id_ctr[side] == '1) ? 16'd1 : id_ctr[side] + 16'd1;
                    end
                    else
                        slots[side][hit_slot].id = r.id;
                    fill[side] = fill[side] + OCC_W'(1);
                end
            end
            ACT_DELETE, ACT_FIND_ID:
            begin
                if (r.act == ACT_DELETE || r.id != '0)
                    for (int k = 0; k < CAP; k++)
                        if (hit_slot < 0 && slots[side][k].valid && slots[side][k].id == r.id)
                            hit_slot = k;
            end
            ACT_FIND_SOCK:
            begin
                if (!r.sock[SOCK_W-1])
                    for (int k = 0; k < CAP; k++)
                        if (hit_slot < 0 && slots[side][k].valid
                            && slots[side][k].sock == r.sock)
                            hit_slot = k;
            end
            default:
            begin
            end
        endcase
        if (hit_slot >= 0)
        begin
            o.hit       = 1'b1;
            o.slot      = hit_slot[SLOT_W-1:0];
            o.id        = slots[side][hit_slot].id;
            o.addr_high = slots[side][hit_slot].addr_high;
            o.addr_low  = slots[side][hit_slot].addr_low;
            o.sock      = slots[side][hit_slot].sock;
            if (r.act == ACT_DELETE)
            begin
                slots[side][hit_slot].valid = 1'b0;
                fill[side] = fill[side] - OCC_W'(1);
            end
        end
        o.occ = fill[side];
        return o;
    endfunction

    function automatic action_result_t queue_item(input table_req_t r);
        pending.push_back(r);
        return apply_action(PLAN, r);
    endfunction

    function automatic table_req_t mk_req(input logic [ACT_W-1:0] act,
                                          input logic [ID_W-1:0] id,
                                          input logic [ADDR_W-1:0] ah,
                                          input logic [ADDR_W-1:0] al,
                                          input logic [SOCK_W-1:0] sock);
        table_req_t r;
        r.calm      = 1'b0;
        r.act       = act;
        r.id        = id;
        r.addr_high = ah;
        r.addr_low  = al;
        r.sock      = sock;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [SOCK_W-1:0] rand_socket();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '1;
        else if (pick == 1)
            return {1'b1, 16'($urandom)};
        else if (pick < 4)
            return SOCK_W'($urandom_range(0, 15));
        return {1'b0, 16'($urandom)};
    endfunction

    function automatic int pick_entry();
        int start;
        int idx;
        if (fill[PLAN] == '0)
            return -1;
        start = $urandom_range(0, CAP - 1);
        for (int k = 0; k < CAP; k++)
        begin
            idx = (start + k) % CAP;
            if (slots[PLAN][idx].valid)
                return idx;
        end
        return -1;
    endfunction

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= 40)
            $display("MISMATCH at result %0d: %s", n_checked, what);
    endtask

    task automatic check_result();
        action_result_t want;
        action_result_t got;
        got.hit       = m_tuser;
        got.slot      = m_tdata[0 +: SLOT_W];
        got.id        = m_tdata[O_ID +: ID_W];
        got.addr_high = m_tdata[O_AH +: ADDR_W];
        got.addr_low  = m_tdata[O_AL +: ADDR_W];
        got.sock      = m_tdata[O_SOCK +: SOCK_W];
        got.occ       = m_tdata[O_OCC +: OCC_W];
        n_checked++;
        if (result_q.size() == 0)
        begin
            report_mismatch("result transfer with no request outstanding");
            return;
        end
        want = result_q.pop_front();
        if (got.hit != want.hit)
            report_mismatch($sformatf("hit %0d, want %0d", got.hit, want.hit));
        if (got.slot != want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
        if (got.id != want.id)
            report_mismatch($sformatf("id %0h, want %0h", got.id, want.id));
        if (got.addr_high != want.addr_high)
            report_mismatch($sformatf("addr_high %h, want %h", got.addr_high, want.addr_high));
        if (got.addr_low != want.addr_low)
            report_mismatch($sformatf("addr_low %h, want %h", got.addr_low, want.addr_low));
        if (got.sock != want.sock)
            report_mismatch($sformatf("socket %h, want %h", got.sock, want.sock));
        if (got.occ != want.occ)
            report_mismatch($sformatf("occupied %0d, want %0d", got.occ, want.occ));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                result_q.push_back(apply_action(LIVE, cur_req));
                if (!cur_req.calm && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 11);
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur_req = pending.pop_front();
                    calm_now <= cur_req.calm;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{PAD_W{1'b0}}, cur_req.sock, cur_req.addr_low,
                                 cur_req.addr_high, cur_req.id};
                    s_tuser  <= cur_req.act;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm_now && $urandom_range(0, 6) == 0)
                    snk_gap = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        table_req_t     r;
        int             k;
        int             seg;
        int             mode;
        int             pick;
        int             add_cut;
        int             copy_cut;
        int             del_cut;

        for (int s = 0; s < 2; s++)
        begin
            fill[s]   = '0;
            id_ctr[s] = 16'd1;
            for (int j = 0; j < CAP; j++)
                slots[s][j] = '0;
        end

        // empty table, extremes of the fields, every action
        void'(queue_item(mk_req(ACT_FIND_ID, 16'd1, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_DELETE, 16'd5, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_ADD, '1, '1, '1, 17'h0FFFF)));
        void'(queue_item(mk_req(ACT_ADD, '0, '0, '0, '1)));
        void'(queue_item(mk_req(ACT_COPY, '0, {32{2'b10}}, {32{2'b01}}, '0)));
        void'(queue_item(mk_req(ACT_COPY, '1, {32{2'b01}}, {32{2'b10}}, 17'd12345)));
        void'(queue_item(mk_req(ACT_FIND_ID, '0, '1, '1, '1)));
        void'(queue_item(mk_req(ACT_FIND_ID, '1, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_FIND_ID, 16'd1, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_FIND_SOCK, '0, '0, '0, '1)));
        void'(queue_item(mk_req(ACT_FIND_SOCK, '0, '0, '0, 17'h1FFFE)));
        void'(queue_item(mk_req(ACT_FIND_SOCK, '0, '0, '0, 17'h0FFFF)));
        void'(queue_item(mk_req(ACT_FIND_SOCK, '0, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_DELETE, '0, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_DELETE, '0, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_ADD, 16'h5A5A, rand64(), rand64(), 17'd7)));
        void'(queue_item(mk_req(ACT_RSVD_MIN, '1, '1, '1, '1)));
        void'(queue_item(mk_req(ACT_RSVD_MID, 16'd1, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_RSVD_MAX, 16'd2, '1, '0, 17'd7)));
        void'(queue_item(mk_req(ACT_DELETE, 16'd2, '0, '0, '0)));
        void'(queue_item(mk_req(ACT_FIND_SOCK, '0, '0, '0, 17'd7)));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            seg  = i / SEG_LEN;
            mode = seg % 3;
            case (mode)
                0:
                begin
                    add_cut = 45; copy_cut = 70; del_cut = 75;
                end
                1:
                begin
                    add_cut = 20; copy_cut = 32; del_cut = 55;
                end
                default:
                begin
                    add_cut = 8; copy_cut = 13; del_cut = 60;
                end
            endcase
            r = mk_req(ACT_FIND_ID, 16'($urandom), rand64(), rand64(), rand_socket());
            r.calm = (seg % 4 == 3);
            pick = $urandom_range(0, 99);
            k = pick_entry();
            if (pick < add_cut)
                r.act = ACT_ADD;
            else if (pick < copy_cut)
            begin
                r.act = ACT_COPY;
                if (k >= 0 && $urandom_range(0, 2) == 0)
                    r.id = slots[PLAN][k].id;
                else if ($urandom_range(0, 7) == 0)
                    r.id = '0;
            end
            else if (pick < del_cut)
            begin
                r.act = ACT_DELETE;
                if (k >= 0 && $urandom_range(0, 3) != 0)
                    r.id = slots[PLAN][k].id;
            end
            else if (pick < del_cut + (100 - del_cut) / 2)
            begin
                r.act = ACT_FIND_ID;
                if (k >= 0 && $urandom_range(0, 3) != 0)
                    r.id = slots[PLAN][k].id;
                else if ($urandom_range(0, 4) == 0)
                    r.id = '0;
            end
            else if (pick < 96)
            begin
                r.act = ACT_FIND_SOCK;
                if (k >= 0 && $urandom_range(0, 3) != 0)
                    r.sock = slots[PLAN][k].sock;
            end
            else
                r.act = ACT_W'($urandom_range(ACT_RSVD_MIN, ACT_RSVD_MAX));
            void'(queue_item(r));
        end

        // drain the table
        while (fill[PLAN] != '0)
        begin
            k = pick_entry();
            r = mk_req(ACT_DELETE, slots[PLAN][k].id, '0, '0, '0);
            r.calm = 1'b1;
            void'(queue_item(r));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_tvalid || result_q.size() != 0)
            @(posedge clk);
        repeat (2 * CAP) @(posedge clk);

        if (err_cnt == 0 && result_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
